[hdl/tdt_pkg.sv]
// Package for the task dispatch table: field widths, operation and status codes,
// and the packed entry type. No dependencies.
`timescale 1ns / 1ps
package tdt_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam int ID_W = 32;
	localparam int WK_W = 16;
	localparam int RT_W = 8;
	localparam int MS_W = 48;
	localparam int CNT_W = 7;

	localparam logic [3:0] K_ADD = 4'd0;
	localparam logic [3:0] K_PEEK = 4'd1;
	localparam logic [3:0] K_ASSIGN = 4'd2;
	localparam logic [3:0] K_COMPLETE = 4'd3;
	localparam logic [3:0] K_FAIL = 4'd4;
	localparam logic [3:0] K_REQUEUE = 4'd5;
	localparam logic [3:0] K_REQ_WORKER = 4'd6;
	localparam logic [3:0] K_FIND = 4'd7;
	localparam logic [3:0] K_STATS = 4'd8;

	localparam logic [2:0] S_OK = 3'd0;
	localparam logic [2:0] S_FAILED = 3'd1;
	localparam logic [2:0] S_NOT_FOUND = 3'd2;
	localparam logic [2:0] S_DUP = 3'd3;
	localparam logic [2:0] S_FULL = 3'd4;
	localparam logic [2:0] S_WRONG = 3'd5;
	localparam logic [2:0] S_MISMATCH = 3'd6;
	localparam logic [2:0] S_NONE = 3'd7;

	localparam logic [2:0] T_PENDING = 3'd0;
	localparam logic [2:0] T_ASSIGNED = 3'd1;
	localparam logic [2:0] T_COMPLETED = 3'd2;
	localparam logic [2:0] T_FAILED = 3'd3;
	localparam logic [2:0] T_REQUEUED = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [2:0] st;
		logic [RT_W-1:0] retries;
		logic [RT_W-1:0] limit;
		logic [WK_W-1:0] worker;
		logic [MS_W-1:0] asg_ms;
		logic [MS_W-1:0] done_ms;
	} entry_t;

	typedef struct packed {
		logic [2:0] status;
		logic has_task;
		logic last;
		logic stats;
	} res_ctl_t;
endpackage

[hdl/tdt_mem.sv]
// Entry memory of the task dispatch table: one write port, one registered read port.
// Depends on tdt_pkg.
`timescale 1ns / 1ps
module tdt_mem #(
	parameter int CAPACITY = tdt_pkg::CAPACITY_DEF,
	parameter int AW = $clog2(CAPACITY)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input tdt_pkg::entry_t wdata,
	input logic [AW-1:0] raddr,
	output tdt_pkg::entry_t rdata
);
	tdt_pkg::entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/task_dispatch_table.sv]
// Task dispatch table: one operation per input item, scanning the entry memory.
// The scan reads each stored entry in RD and inspects it in CHK; a hit at an entry ends the scan
// early. The result item is offered in OUT after the hit or after the last stored entry.
// One item at a time: the next input item is taken only after the last result item is accepted;
// requeue worker offers one more result item per further matching entry, and an output stall holds OUT.
// Reset: arst_n clears the entry count and control; entry contents are undefined until added.
`timescale 1ns / 1ps
module task_dispatch_table #(
	parameter int CAPACITY = tdt_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// kind[3:0]
	input logic [3:0] s_tuser,
	// task_id[31:0], worker_tag[47:32], initial_retries[55:48], retry_limit[63:56],
	// now_ms[111:64]
	input logic [111:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status[2:0], result_task_id[34:3], task_state[37:35], retries[45:38],
	// stamp_ms[93:46], pending..total counts 7 bits each [135:94], zeros[143:136]
	output logic [143:0] m_tdata,
	output logic m_tlast
);
	localparam int AW = $clog2(CAPACITY);
	localparam int NW = $clog2(CAPACITY + 1);

	// RD presents an address to the memory, CHK looks at the entry that comes back,
	// OUT offers one result item.
	typedef enum logic [1:0] {IDLE, RD, CHK, OUT} st_t;
	st_t state_q;

	logic [3:0] kind_q;
	logic [tdt_pkg::ID_W-1:0] id_q;
	logic [tdt_pkg::WK_W-1:0] wk_q;
	logic [tdt_pkg::RT_W-1:0] ir_q, lim_q;
	logic [tdt_pkg::MS_W-1:0] now_q;
	logic [NW-1:0] count_q, idx_q;
	logic held_q;
	logic [tdt_pkg::CNT_W-1:0] cnt_q [5];

	tdt_pkg::entry_t rd, wdata;
	logic we;
	logic [AW-1:0] waddr, raddr;

	tdt_pkg::res_ctl_t ctl_q;
	tdt_pkg::entry_t ent_q;

	// The shared unit: one compare/update of the entry just read.
	logic hit_id, hit_wk, hit_peek, sat, scan_end;
	logic [tdt_pkg::RT_W-1:0] rinc;
	tdt_pkg::entry_t rq, upd, added;
	logic [2:0] rq_st, upd_status;
	logic upd_we, chk_we;
	assign hit_id = rd.id == id_q;
	assign hit_wk = rd.st == tdt_pkg::T_ASSIGNED && rd.worker == wk_q;
	assign hit_peek = rd.st == tdt_pkg::T_PENDING || rd.st == tdt_pkg::T_REQUEUED;
	assign sat = rd.retries == 8'hFF;
	assign rinc = sat ? rd.retries : rd.retries + 8'd1;
	assign scan_end = idx_q == count_q || kind_q > tdt_pkg::K_STATS;
	assign added = '{id: id_q, st: tdt_pkg::T_PENDING, retries: ir_q, limit: lim_q,
		worker: '0, asg_ms: '0, done_ms: '0};

	always_comb begin
		rq = rd;
		rq.retries = rinc;
		if (rinc > rd.limit) begin
			rq.st = tdt_pkg::T_FAILED;
			rq.done_ms = now_q;
			rq_st = tdt_pkg::S_FAILED;
		end else begin
			rq.st = tdt_pkg::T_REQUEUED;
			rq.worker = '0;
			rq.asg_ms = '0;
			rq_st = tdt_pkg::S_OK;
		end
	end

	// New contents and answer for an entry that matched the operation.
	always_comb begin
		upd = rd;
		upd_status = tdt_pkg::S_OK;
		upd_we = 1'b0;
		case (kind_q)
			tdt_pkg::K_ASSIGN: begin
				if (!hit_peek) begin
					upd_status = tdt_pkg::S_WRONG;
				end else begin
					upd.st = tdt_pkg::T_ASSIGNED;
					upd.worker = wk_q;
					upd.asg_ms = now_q;
					upd_we = 1'b1;
				end
			end
			tdt_pkg::K_COMPLETE: begin
				if (rd.st != tdt_pkg::T_ASSIGNED) begin
					upd_status = tdt_pkg::S_WRONG;
				end else if (rd.worker != wk_q) begin
					upd_status = tdt_pkg::S_MISMATCH;
				end else begin
					upd.st = tdt_pkg::T_COMPLETED;
					upd.done_ms = now_q;
					upd_we = 1'b1;
				end
			end
			tdt_pkg::K_FAIL: begin
				upd.st = tdt_pkg::T_FAILED;
				upd.done_ms = now_q;
				upd_we = 1'b1;
			end
			tdt_pkg::K_REQUEUE: begin
				if (rd.st == tdt_pkg::T_COMPLETED || rd.st == tdt_pkg::T_FAILED) begin
					upd_status = tdt_pkg::S_WRONG;
				end else begin
					upd = rq;
					upd_status = rq_st;
					upd_we = 1'b1;
				end
			end
			tdt_pkg::K_REQ_WORKER: begin
				upd = rq;
				upd_status = rq_st;
				upd_we = 1'b1;
			end
			default: ;
		endcase
	end

	// A requeue-worker match is written only once, when it is taken into the hold registers.
	always_comb begin
		case (kind_q)
			tdt_pkg::K_REQ_WORKER: chk_we = hit_wk && !held_q;
			tdt_pkg::K_ASSIGN, tdt_pkg::K_COMPLETE, tdt_pkg::K_FAIL, tdt_pkg::K_REQUEUE:
				chk_we = hit_id && upd_we;
			default: chk_we = 1'b0;
		endcase
	end

	// Adds are written at the scan end, updates in the cycle that inspects the entry.
	assign we = (state_q == RD && scan_end && kind_q == tdt_pkg::K_ADD &&
		count_q != NW'(CAPACITY)) || (state_q == CHK && chk_we);
	assign wdata = (state_q == RD) ? added : upd;
	assign raddr = idx_q[AW-1:0];
	assign waddr = idx_q[AW-1:0];

	tdt_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
	);

	assign s_tready = state_q == IDLE;

	// Result control fields in order: status, has_task, last, stats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			m_tvalid <= 1'b0;
			idx_q <= '0;
			held_q <= 1'b0;
			kind_q <= '0;
			id_q <= '0;
			wk_q <= '0;
			ir_q <= '0;
			lim_q <= '0;
			now_q <= '0;
			ctl_q <= '0;
			ent_q <= '0;
			for (int k = 0; k < 5; k++) cnt_q[k] <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						kind_q <= s_tuser;
						id_q <= s_tdata[31:0];
						wk_q <= s_tdata[47:32];
						ir_q <= s_tdata[55:48];
						lim_q <= s_tdata[63:56];
						now_q <= s_tdata[111:64];
						idx_q <= '0;
						held_q <= 1'b0;
						for (int k = 0; k < 5; k++) cnt_q[k] <= '0;
						state_q <= RD;
					end
				end
				RD: begin
					// Scan end: decide the final answer.
					if (scan_end) begin
						state_q <= OUT;
						case (kind_q)
							tdt_pkg::K_ADD: begin
								if (count_q == NW'(CAPACITY)) begin
									ctl_q <= '{tdt_pkg::S_FULL, 1'b0, 1'b1, 1'b0};
								end else begin
									ent_q <= added;
									count_q <= count_q + 1'b1;
									ctl_q <= '{tdt_pkg::S_OK, 1'b1, 1'b1, 1'b0};
								end
							end
							tdt_pkg::K_STATS: ctl_q <= '{tdt_pkg::S_OK, 1'b0, 1'b1, 1'b1};
							tdt_pkg::K_REQ_WORKER: begin
								// The held result becomes the last one.
								if (held_q) ctl_q.last <= 1'b1;
								else ctl_q <= '{tdt_pkg::S_NONE, 1'b0, 1'b1, 1'b0};
							end
							tdt_pkg::K_ASSIGN, tdt_pkg::K_COMPLETE, tdt_pkg::K_FAIL,
							tdt_pkg::K_REQUEUE, tdt_pkg::K_FIND:
								ctl_q <= '{tdt_pkg::S_NOT_FOUND, 1'b0, 1'b1, 1'b0};
							default: ctl_q <= '{tdt_pkg::S_NONE, 1'b0, 1'b1, 1'b0};
						endcase
					end else begin
						state_q <= CHK;
					end
				end
				CHK: begin
					case (kind_q)
						tdt_pkg::K_STATS: begin
							if (rd.st <= tdt_pkg::T_REQUEUED)
								cnt_q[rd.st] <= cnt_q[rd.st] + 1'b1;
							idx_q <= idx_q + 1'b1;
							state_q <= RD;
						end
						tdt_pkg::K_PEEK: begin
							if (hit_peek) begin
								ent_q <= rd;
								ctl_q <= '{tdt_pkg::S_OK, 1'b1, 1'b1, 1'b0};
								state_q <= OUT;
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= RD;
							end
						end
						tdt_pkg::K_ADD: begin
							if (hit_id) begin
								ctl_q <= '{tdt_pkg::S_DUP, 1'b0, 1'b1, 1'b0};
								state_q <= OUT;
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= RD;
							end
						end
						tdt_pkg::K_REQ_WORKER: begin
							if (!hit_wk) begin
								idx_q <= idx_q + 1'b1;
								state_q <= RD;
							end else if (held_q) begin
								// Another match: the held result is not the last one, so
								// send it and come back to this entry afterwards.
								state_q <= OUT;
							end else begin
								ent_q <= upd;
								ctl_q <= '{upd_status, 1'b1, 1'b0, 1'b0};
								held_q <= 1'b1;
								idx_q <= idx_q + 1'b1;
								state_q <= RD;
							end
						end
						default: begin
							if (hit_id) begin
								ent_q <= upd;
								ctl_q <= '{upd_status, 1'b1, 1'b1, 1'b0};
								state_q <= OUT;
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= RD;
							end
						end
					endcase
				end
				OUT: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
					end else if (m_tready) begin
						m_tvalid <= 1'b0;
						if (ctl_q.last) begin
							state_q <= IDLE;
						end else begin
							held_q <= 1'b0;
							state_q <= RD;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Requeue worker holds each result in ent_q and ctl_q until the next match or the scan
	// end, so that the final one can be marked as last.
	logic [143:0] pay;
	logic [tdt_pkg::MS_W-1:0] stamp;
	assign stamp = (ent_q.st == tdt_pkg::T_COMPLETED || ent_q.st == tdt_pkg::T_FAILED)
		? ent_q.done_ms : ent_q.asg_ms;
	always_comb begin
		pay = '0;
		pay[2:0] = ctl_q.status;
		if (ctl_q.has_task) begin
			pay[34:3] = ent_q.id;
			pay[37:35] = ent_q.st;
			pay[45:38] = ent_q.retries;
			pay[93:46] = stamp;
		end
		if (ctl_q.stats) begin
			pay[100:94] = cnt_q[0];
			pay[107:101] = cnt_q[1];
			pay[114:108] = cnt_q[2];
			pay[121:115] = cnt_q[3];
			pay[128:122] = cnt_q[4];
			pay[135:129] = tdt_pkg::CNT_W'(count_q);
		end
	end
	assign m_tdata = pay;
	assign m_tlast = ctl_q.last;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("ready while result pending");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(CAPACITY)) else $error("entry count overflow");
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> state_q == OUT) else $error("result outside output state");
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> kind_q == tdt_pkg::K_REQ_WORKER)
		else $error("non-final result outside requeue worker");
endmodule
